FILE: rtl/stgc_pkg.sv
// ----------------------------------------------------------------------------
// stgc_pkg
// Shared types, constants, saturation helpers and sine table for the stereo
// transient gain compressor.
// ----------------------------------------------------------------------------
package stgc_pkg;

	localparam int SAMPLE_BITS      = 24;
	localparam int DELAY_DEPTH      = 128;
	localparam int SINE_TABLE_DEPTH = 256;

	localparam int DW      = SAMPLE_BITS + 2;
	localparam int AW      = $clog2(DELAY_DEPTH);
	localparam int SIN_AW  = $clog2(SINE_TABLE_DEPTH);
	localparam int SIN_W   = 22;
	localparam int G_W     = 25;
	localparam int TRIM_W  = 17;
	localparam int OFS_W   = 7;
	localparam int WET_W   = 16;
	localparam int CFG_IW  = 2;
	localparam int CFG_DW  = 17;
	localparam int MUL_W   = 34;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int V_W     = 44;
	localparam int REM_W   = 35;
	localparam int QE_W    = 12;
	localparam int ACC_W   = 46;
	localparam int SAT_W   = 48;
	localparam int MAG_W   = DW + 1;

	localparam int PH_RSH  = (SAMPLE_BITS + 7 >= 30) ? SAMPLE_BITS - 23 : 0;
	localparam int PH_LSH  = (SAMPLE_BITS + 7 < 30) ? 23 - SAMPLE_BITS : 0;

	localparam longint unsigned Q30_ONE     = 64'd1073741824;
	localparam longint unsigned PI_Q30      = 64'd3373259426;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
	localparam longint unsigned HALF_C      = TWO_PI_Q30 / 2;
	localparam longint unsigned RECIP       = (64'd1 << 46) / TWO_PI_Q30;
	localparam longint unsigned GAIN_ONE    = 64'd1048576;

	localparam logic [TRIM_W-1:0] TRIM_ONE  = TRIM_W'(16384);
	localparam logic [WET_W:0]    WET_ONE   = (WET_W+1)'(32768);

	typedef enum logic [CFG_IW-1:0] {
		CFG_TRIM   = 2'd0,
		CFG_OFFSET = 2'd1,
		CFG_WET    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_in;
		logic signed [SAMPLE_BITS-1:0] right_in;
	} frame_in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
	} frame_out_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_TL, ST_TR, ST_WR, ST_DF, ST_PH, ST_SH,
		ST_DV0, ST_DV1, ST_DV2, ST_DV3, ST_DV4, ST_NX, ST_SN,
		ST_G1, ST_G2, ST_G3, ST_CL, ST_O1, ST_O2, ST_O3, ST_O4, ST_OUT
	} state_t;

	typedef logic signed [SIN_W-1:0] sine_tab_t [SINE_TABLE_DEPTH];

	function automatic sine_tab_t build_sine();
		sine_tab_t tab;
		longint unsigned a, x2, t, s, r;
		logic neg;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			a = longint'(i) * TWO_PI_Q30 / SINE_TABLE_DEPTH;
			neg = 1'b0;
			if (a >= PI_Q30) begin
				a = a - PI_Q30;
				neg = 1'b1;
			end
			if (a > HALF_PI_Q30)
				a = PI_Q30 - a;
			x2 = (a * a) >> 30;
			t = Q30_ONE;
			t = Q30_ONE - ((x2 * t) >> 30) / 156;
			t = Q30_ONE - ((x2 * t) >> 30) / 110;
			t = Q30_ONE - ((x2 * t) >> 30) / 72;
			t = Q30_ONE - ((x2 * t) >> 30) / 42;
			t = Q30_ONE - ((x2 * t) >> 30) / 20;
			t = Q30_ONE - ((x2 * t) >> 30) / 6;
			s = (a * t) >> 30;
			r = (s + 64'd512) >> 10;
			if (r > GAIN_ONE)
				r = GAIN_ONE;
			tab[i] = neg ? -SIN_W'(r) : SIN_W'(r);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine();

	function automatic logic signed [DW-1:0] sat_dw(input logic signed [SAT_W-1:0] v);
		if (v[SAT_W-1] && !(&v[SAT_W-1:DW-1]))
			return {1'b1, {(DW-1){1'b0}}};
		else if (!v[SAT_W-1] && (|v[SAT_W-1:DW-1]))
			return {1'b0, {(DW-1){1'b1}}};
		else
			return v[DW-1:0];
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sb(input logic signed [SAT_W-1:0] v);
		if (v[SAT_W-1] && !(&v[SAT_W-1:SAMPLE_BITS-1]))
			return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		else if (!v[SAT_W-1] && (|v[SAT_W-1:SAMPLE_BITS-1]))
			return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		else
			return v[SAMPLE_BITS-1:0];
	endfunction

endpackage

FILE: rtl/stereo_transient_gain_compressor.sv
// ----------------------------------------------------------------------------
// stereo_transient_gain_compressor
// Per-frame trim, delay-ring transient detection through a sine table,
// shared gain update, wet/dry mix and saturation.
// ----------------------------------------------------------------------------
//  channel | signals                        | transfer when
//  --------+--------------------------------+-------------------------
//  input   | in_valid, in_ready, in_data    | in_valid && in_ready
//  output  | out_valid, out_ready, out_data | out_valid && out_ready
//  config  | cfg_valid, cfg_ready, cfg_*    | cfg_valid && cfg_ready
//
// Frames are taken one at a time: in_ready stays low from the input transfer
// until the sequencer is back in idle. The sequencer runs around one shared
// 34x34 multiplier (two phase mod/index passes per side). Delay rings live
// in two RAMs; per-entry valid bits read as zero after reset, so no clearing
// pass. A pending result waits in the output register while the next frame
// is taken; the sequencer stalls at its end only if that register is still
// full.
module stereo_transient_gain_compressor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  stgc_pkg::frame_in_t           in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output stgc_pkg::frame_out_t          out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [stgc_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [stgc_pkg::CFG_DW-1:0]   cfg_data
);

	stgc_pkg::state_t state_q, state_d;

	logic [stgc_pkg::TRIM_W-1:0]              trim_q;
	logic [stgc_pkg::OFS_W-1:0]               ofs_q;
	logic [stgc_pkg::WET_W-1:0]               wet_q;

	logic [stgc_pkg::AW-1:0]                  wp_q;
	logic [stgc_pkg::DELAY_DEPTH-1:0]         valid_q;
	logic                                     dvalid_q;
	logic signed [stgc_pkg::SAMPLE_BITS-1:0]  x_l_q, x_r_q;
	logic signed [stgc_pkg::DW-1:0]           t_l_q, t_r_q, d_l_q, d_r_q;
	logic                                     k_neg_q;
	logic [stgc_pkg::TRIM_W-1:0]              kk_q;
	logic [stgc_pkg::MAG_W-1:0]               mag_q;
	logic signed [stgc_pkg::PROD_W-1:0]       prod_q;
	logic [stgc_pkg::V_W-1:0]                 v_q;
	logic [stgc_pkg::REM_W-1:0]               rem_q;
	logic [stgc_pkg::QE_W-1:0]                quo_q;
	logic                                     pass_q, side_q;
	logic signed [stgc_pkg::SIN_W-1:0]        sine_q;
	logic signed [stgc_pkg::G_W-1:0]          g_q, gtmp_q;
	logic signed [stgc_pkg::ACC_W-1:0]        acc_q;
	logic signed [stgc_pkg::SAMPLE_BITS-1:0]  y_l_q, y_r_q;
	logic                                     out_valid_q;
	stgc_pkg::frame_out_t                     out_data_q;

	logic signed [stgc_pkg::MUL_W-1:0]        mul_a, mul_b;
	logic [stgc_pkg::AW-1:0]                  wp_next, raddr;
	logic                                     ram_re, ram_we, accept, out_load;
	logic [stgc_pkg::DW-1:0]                  rd_l, rd_r;
	logic signed [stgc_pkg::DW-1:0]           t_r_new, t_side, d_side, d_sel;
	logic signed [stgc_pkg::DW:0]             diff;
	logic signed [stgc_pkg::SIN_W:0]          om;
	logic signed [stgc_pkg::SAMPLE_BITS-1:0]  x_side;
	logic signed [stgc_pkg::ACC_W-1:0]        mix_sum;
	logic signed [stgc_pkg::SAMPLE_BITS-1:0]  y_new;
	logic                                     rem_ge;
	logic signed [stgc_pkg::SIN_W-1:0]        tab_val;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign accept    = in_valid && in_ready;
	assign out_load  = (state_q == stgc_pkg::ST_OUT) && (!out_valid_q || out_ready);

	assign wp_next = wp_q - 1'b1;
	assign raddr   = wp_next + stgc_pkg::AW'(ofs_q);

	stgc_ram #(.WIDTH(stgc_pkg::DW), .DEPTH(stgc_pkg::DELAY_DEPTH)) u_ram_l (
		.clk(clk), .we(ram_we), .waddr(wp_q), .wdata(t_l_q),
		.re(ram_re), .raddr(raddr), .rdata(rd_l)
	);

	stgc_ram #(.WIDTH(stgc_pkg::DW), .DEPTH(stgc_pkg::DELAY_DEPTH)) u_ram_r (
		.clk(clk), .we(ram_we), .waddr(wp_q), .wdata(t_r_new),
		.re(ram_re), .raddr(raddr), .rdata(rd_r)
	);

	assign t_r_new = stgc_pkg::sat_dw(signed'(prod_q[14 +: stgc_pkg::SAT_W]));
	assign t_side  = side_q ? t_r_q : t_l_q;
	assign d_side  = side_q ? d_r_q : d_l_q;
	assign x_side  = side_q ? x_r_q : x_l_q;
	assign d_sel   = (stgc_pkg::AW'(ofs_q) == '0) ? t_side : (dvalid_q ? d_side : '0);
	assign diff    = (stgc_pkg::DW+1)'(t_side) - (stgc_pkg::DW+1)'(d_sel);
	assign om      = (stgc_pkg::SIN_W+1)'(stgc_pkg::GAIN_ONE) - (stgc_pkg::SIN_W+1)'(sine_q);
	assign mix_sum = acc_q + prod_q[stgc_pkg::ACC_W-1:0];
	assign y_new   = stgc_pkg::sat_sb(stgc_pkg::SAT_W'(mix_sum >>> 15));
	assign rem_ge  = rem_q >= stgc_pkg::REM_W'(stgc_pkg::TWO_PI_Q30);
	assign tab_val = stgc_pkg::SINE_TAB[quo_q[stgc_pkg::SIN_AW-1:0]];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stgc_pkg::ST_IDLE: if (accept) state_d = stgc_pkg::ST_TL;
			stgc_pkg::ST_TL:   state_d = stgc_pkg::ST_TR;
			stgc_pkg::ST_TR:   state_d = stgc_pkg::ST_WR;
			stgc_pkg::ST_WR:   state_d = stgc_pkg::ST_DF;
			stgc_pkg::ST_DF:   state_d = stgc_pkg::ST_PH;
			stgc_pkg::ST_PH:   state_d = stgc_pkg::ST_SH;
			stgc_pkg::ST_SH:   state_d = stgc_pkg::ST_DV0;
			stgc_pkg::ST_DV0:  state_d = stgc_pkg::ST_DV1;
			stgc_pkg::ST_DV1:  state_d = stgc_pkg::ST_DV2;
			stgc_pkg::ST_DV2:  state_d = stgc_pkg::ST_DV3;
			stgc_pkg::ST_DV3:  state_d = stgc_pkg::ST_DV4;
			stgc_pkg::ST_DV4:  state_d = pass_q ? stgc_pkg::ST_SN : stgc_pkg::ST_NX;
			stgc_pkg::ST_NX:   state_d = stgc_pkg::ST_DV0;
			stgc_pkg::ST_SN:   state_d = stgc_pkg::ST_G1;
			stgc_pkg::ST_G1:   state_d = stgc_pkg::ST_G2;
			stgc_pkg::ST_G2:   state_d = stgc_pkg::ST_G3;
			stgc_pkg::ST_G3:   state_d = side_q ? stgc_pkg::ST_CL : stgc_pkg::ST_DF;
			stgc_pkg::ST_CL:   state_d = stgc_pkg::ST_O1;
			stgc_pkg::ST_O1:   state_d = stgc_pkg::ST_O2;
			stgc_pkg::ST_O2:   state_d = stgc_pkg::ST_O3;
			stgc_pkg::ST_O3:   state_d = stgc_pkg::ST_O4;
			stgc_pkg::ST_O4:   state_d = side_q ? stgc_pkg::ST_OUT : stgc_pkg::ST_O1;
			stgc_pkg::ST_OUT:  if (out_load) state_d = stgc_pkg::ST_IDLE;
			default:           state_d = stgc_pkg::ST_IDLE;
		endcase
	end

	// outputs: handshake, RAM control, multiplier operands
	always_comb begin
		in_ready = 1'b0;
		ram_re   = 1'b0;
		ram_we   = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			stgc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				ram_re   = accept;
			end
			stgc_pkg::ST_TL: begin
				mul_a = stgc_pkg::MUL_W'(x_l_q);
				mul_b = stgc_pkg::MUL_W'(trim_q);
			end
			stgc_pkg::ST_TR: begin
				mul_a = stgc_pkg::MUL_W'(x_r_q);
				mul_b = stgc_pkg::MUL_W'(trim_q);
			end
			stgc_pkg::ST_WR: ram_we = 1'b1;
			stgc_pkg::ST_PH: begin
				mul_a = stgc_pkg::MUL_W'(mag_q);
				mul_b = stgc_pkg::MUL_W'(kk_q);
			end
			stgc_pkg::ST_DV0: begin
				mul_a = stgc_pkg::MUL_W'(v_q >> 30);
				mul_b = stgc_pkg::MUL_W'(stgc_pkg::RECIP);
			end
			stgc_pkg::ST_DV1: begin
				mul_a = stgc_pkg::MUL_W'(prod_q[stgc_pkg::QE_W+15:16]);
				mul_b = stgc_pkg::MUL_W'(stgc_pkg::TWO_PI_Q30);
			end
			stgc_pkg::ST_G1: begin
				mul_a = stgc_pkg::MUL_W'(g_q);
				mul_b = stgc_pkg::MUL_W'(om);
			end
			stgc_pkg::ST_G2: begin
				mul_a = stgc_pkg::MUL_W'(om);
				mul_b = stgc_pkg::MUL_W'(sine_q);
			end
			stgc_pkg::ST_O1: begin
				mul_a = stgc_pkg::MUL_W'(t_side);
				mul_b = stgc_pkg::MUL_W'(g_q);
			end
			stgc_pkg::ST_O2: begin
				mul_a = stgc_pkg::MUL_W'(prod_q >>> 20);
				mul_b = stgc_pkg::MUL_W'(wet_q);
			end
			stgc_pkg::ST_O3: begin
				mul_a = stgc_pkg::MUL_W'(x_side);
				mul_b = stgc_pkg::MUL_W'(signed'(stgc_pkg::WET_ONE - {1'b0, wet_q}));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stgc_pkg::ST_IDLE;
			trim_q      <= stgc_pkg::TRIM_ONE;
			ofs_q       <= stgc_pkg::OFS_W'(1);
			wet_q       <= stgc_pkg::WET_W'(32768);
			wp_q        <= '0;
			valid_q     <= '0;
			g_q         <= stgc_pkg::G_W'(stgc_pkg::GAIN_ONE);
			pass_q      <= 1'b0;
			side_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					stgc_pkg::CFG_TRIM:   trim_q <= cfg_data[stgc_pkg::TRIM_W-1:0];
					stgc_pkg::CFG_OFFSET: ofs_q  <= cfg_data[stgc_pkg::OFS_W-1:0];
					stgc_pkg::CFG_WET:    wet_q  <= cfg_data[stgc_pkg::WET_W-1:0];
					default: ;
				endcase
			end
			if (accept)
				wp_q <= wp_next;
			if (ram_we)
				valid_q[wp_q] <= 1'b1;
			if (state_q == stgc_pkg::ST_SH)
				pass_q <= 1'b0;
			else if (state_q == stgc_pkg::ST_NX)
				pass_q <= 1'b1;
			if (state_q == stgc_pkg::ST_WR || state_q == stgc_pkg::ST_CL)
				side_q <= 1'b0;
			else if (state_q == stgc_pkg::ST_G3 || state_q == stgc_pkg::ST_O4)
				side_q <= ~side_q;
			if (state_q == stgc_pkg::ST_G3)
				g_q <= gtmp_q + stgc_pkg::G_W'(prod_q >>> 20);
			else if (state_q == stgc_pkg::ST_CL) begin
				if (g_q > signed'(stgc_pkg::G_W'(stgc_pkg::GAIN_ONE)))
					g_q <= stgc_pkg::G_W'(stgc_pkg::GAIN_ONE);
				else if (g_q < 0)
					g_q <= '0;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			x_l_q    <= in_data.left_in;
			x_r_q    <= in_data.right_in;
			dvalid_q <= valid_q[raddr];
		end
		case (state_q) inside
			stgc_pkg::ST_TL: begin
				d_l_q   <= rd_l;
				d_r_q   <= rd_r;
				k_neg_q <= trim_q < stgc_pkg::TRIM_ONE;
				kk_q    <= (trim_q < stgc_pkg::TRIM_ONE) ? stgc_pkg::TRIM_ONE - trim_q
				                                         : trim_q - stgc_pkg::TRIM_ONE;
			end
			stgc_pkg::ST_TR: t_l_q <= t_r_new;
			stgc_pkg::ST_WR: t_r_q <= t_r_new;
			stgc_pkg::ST_DF: mag_q <= diff[stgc_pkg::DW] ? stgc_pkg::MAG_W'(-diff)
			                                             : stgc_pkg::MAG_W'(diff);
			stgc_pkg::ST_SH: v_q <= stgc_pkg::V_W'(
				(prod_q[stgc_pkg::V_W:0] >> stgc_pkg::PH_RSH) << stgc_pkg::PH_LSH);
			stgc_pkg::ST_DV1: quo_q <= prod_q[stgc_pkg::QE_W+15:16];
			stgc_pkg::ST_DV2: rem_q <= stgc_pkg::REM_W'(v_q - prod_q[stgc_pkg::V_W-1:0]);
			stgc_pkg::ST_DV3, stgc_pkg::ST_DV4: begin
				if (rem_ge) begin
					rem_q <= rem_q - stgc_pkg::REM_W'(stgc_pkg::TWO_PI_Q30);
					quo_q <= quo_q + 1'b1;
				end
			end
			stgc_pkg::ST_NX: v_q <= (stgc_pkg::V_W'(rem_q) << stgc_pkg::SIN_AW)
			                        + stgc_pkg::V_W'(stgc_pkg::HALF_C);
			stgc_pkg::ST_SN: sine_q <= k_neg_q ? -tab_val : tab_val;
			stgc_pkg::ST_G2: gtmp_q <= stgc_pkg::G_W'(prod_q >>> 20);
			stgc_pkg::ST_O3: acc_q <= prod_q[stgc_pkg::ACC_W-1:0];
			stgc_pkg::ST_O4: begin
				if (side_q)
					y_r_q <= y_new;
				else
					y_l_q <= y_new;
			end
			stgc_pkg::ST_OUT: begin
				if (out_load) begin
					out_data_q.left_out  <= y_l_q;
					out_data_q.right_out <= y_r_q;
				end
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == stgc_pkg::ST_IDLE |->
			g_q >= 0 && g_q <= stgc_pkg::G_W'(stgc_pkg::GAIN_ONE))
		else $error("gain state out of range");

	a_rem_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == stgc_pkg::ST_SN |-> !rem_ge &&
			quo_q <= stgc_pkg::QE_W'(stgc_pkg::SINE_TABLE_DEPTH))
		else $error("phase reduction incomplete");

	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second frame taken while busy");

	a_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> $past(state_q) == stgc_pkg::ST_TR)
		else $error("ring write outside frame sequence");
`endif

endmodule

FILE: rtl/stgc_ram.sv
// ----------------------------------------------------------------------------
// stgc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stgc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

FILE: test/stgc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stgc_checker
// Watches the config, input and output channels of the stereo transient gain
// compressor, predicts each output frame and compares it field by field.
// ----------------------------------------------------------------------------
module stgc_checker
	import stgc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  frame_in_t            in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  frame_out_t           out_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IW-1:0]    cfg_index,
	input  logic [CFG_DW-1:0]    cfg_data,
	output int                   errors,
	output int                   pending
);

	localparam longint unsigned STEP_DIV [6] = '{156, 110, 72, 42, 20, 6};

	longint trim_reg, ofs_reg, wet_reg;
	longint ring_l [DELAY_DEPTH];
	longint ring_r [DELAY_DEPTH];
	int     wr_ptr;
	longint gain_q20;
	frame_out_t expected_frames [$];

	function automatic longint sat_to(longint x, int w);
		longint lim;
		lim = longint'(1) <<< (w - 1);
		if (x > lim - 1)
			return lim - 1;
		if (x < -lim)
			return -lim;
		return x;
	endfunction

	function automatic longint sine_of(longint unsigned idx);
		longint unsigned a, x2, t, s, r;
		logic neg;
		a = idx * TWO_PI_Q30 / SINE_TABLE_DEPTH;
		neg = 1'b0;
		if (a >= PI_Q30) begin
			a -= PI_Q30;
			neg = 1'b1;
		end
		if (a > HALF_PI_Q30)
			a = PI_Q30 - a;
		x2 = (a * a) >> 30;
		t = Q30_ONE;
		for (int i = 0; i < 6; i++)
			t = Q30_ONE - ((x2 * t) >> 30) / STEP_DIV[i];
		s = (a * t) >> 30;
		r = (s + 512) >> 10;
		if (r > GAIN_ONE)
			r = GAIN_ONE;
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint transient_sine(longint diff, longint k);
		longint unsigned mag, kk, p, idx;
		longint v;
		mag = diff < 0 ? -diff : diff;
		kk = k < 0 ? -k : k;
		p = mag * kk;
		if (SAMPLE_BITS + 7 >= 30)
			p = p >> (SAMPLE_BITS - 23);
		else
			p = p << (23 - SAMPLE_BITS);
		idx = ((p % TWO_PI_Q30) * SINE_TABLE_DEPTH + TWO_PI_Q30 / 2) / TWO_PI_Q30;
		if (idx >= SINE_TABLE_DEPTH)
			idx -= SINE_TABLE_DEPTH;
		v = sine_of(idx);
		return k < 0 ? -v : v;
	endfunction

	function automatic longint next_gain(longint g, longint c);
		longint om;
		om = longint'(GAIN_ONE) - c;
		return ((g * om) >>> 20) + ((om * c) >>> 20);
	endfunction

	task automatic compress_frame(input frame_in_t f);
		longint xl, xr, k, tl, tr, g, yl, yr;
		int rd;
		frame_out_t o;
		xl = longint'(f.left_in);
		xr = longint'(f.right_in);
		k = trim_reg - 16384;
		tl = sat_to((xl * trim_reg) >>> 14, DW);
		tr = sat_to((xr * trim_reg) >>> 14, DW);
		wr_ptr = (wr_ptr + DELAY_DEPTH - 1) % DELAY_DEPTH;
		ring_l[wr_ptr] = tl;
		ring_r[wr_ptr] = tr;
		rd = (wr_ptr + int'(ofs_reg)) % DELAY_DEPTH;
		g = next_gain(gain_q20, transient_sine(tl - ring_l[rd], k));
		g = next_gain(g, transient_sine(tr - ring_r[rd], k));
		if (g > longint'(GAIN_ONE))
			g = GAIN_ONE;
		if (g < 0)
			g = 0;
		gain_q20 = g;
		yl = (((tl * g) >>> 20) * wet_reg + xl * (32768 - wet_reg)) >>> 15;
		yr = (((tr * g) >>> 20) * wet_reg + xr * (32768 - wet_reg)) >>> 15;
		o.left_out = SAMPLE_BITS'(sat_to(yl, SAMPLE_BITS));
		o.right_out = SAMPLE_BITS'(sat_to(yr, SAMPLE_BITS));
		expected_frames.push_back(o);
	endtask

	assign pending = expected_frames.size();

	initial begin
		errors = 0;
		trim_reg = 16384;
		ofs_reg = 1;
		wet_reg = 32768;
		wr_ptr = 0;
		gain_q20 = GAIN_ONE;
		foreach (ring_l[i]) begin
			ring_l[i] = 0;
			ring_r[i] = 0;
		end
	end

	always @(posedge clk) begin
		frame_out_t e;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_TRIM:   trim_reg = cfg_data[TRIM_W-1:0];
					CFG_OFFSET: ofs_reg = cfg_data[OFS_W-1:0];
					CFG_WET:    wet_reg = cfg_data[WET_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				compress_frame(in_data);
			if (out_valid && out_ready) begin
				if (expected_frames.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected output transfer %h", out_data);
				end else begin
					e = expected_frames.pop_front();
					if (e.left_out !== out_data.left_out
							|| e.right_out !== out_data.right_out) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected L=%0d R=%0d got L=%0d R=%0d",
								e.left_out, e.right_out,
								out_data.left_out, out_data.right_out);
					end
				end
			end
		end
	end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives config writes and stereo frames into the compressor with random
// gaps and output stalls; the checker predicts and compares every frame.
// ----------------------------------------------------------------------------
module testbench;
	import stgc_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	frame_in_t          in_data;
	logic               out_valid;
	logic               out_ready;
	frame_out_t         out_data;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CFG_IW-1:0]  cfg_index;
	logic [CFG_DW-1:0]  cfg_data;
	int                 errors;
	int                 pending;
	bit                 hold_out;

	stereo_transient_gain_compressor dut (.*);

	stgc_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic write_reg(input cfg_idx_t idx, input int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DW'(value);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_frame(input logic [23:0] l, input logic [23:0] r, input bit gap);
		int wait_n;
		wait_n = gap ? $urandom_range(0, 19) : 0;
		repeat (wait_n) @(negedge clk);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data.left_in <= l;
		in_data.right_in <= r;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'($urandom_range(0, 255)) - 24'd128;
			default: return 24'($urandom);
		endcase
	endfunction

	// output side: random stalls, plus one long hold-off
	initial begin
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_out && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (600) @(negedge clk);
			end
			if ($urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin
		#100ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	localparam int TRIMS [4] = '{16384, 65536, 131071, 0};
	localparam int OFSS  [4] = '{1, 127, 0, 64};
	localparam int WETS  [4] = '{32768, 0, 65535, 16384};

	initial begin
		hold_out = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TRIM;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes at reset settings, then 4x trim
		send_frame(24'h7FFFFF, 24'h800000, 0);
		send_frame(24'h800000, 24'h7FFFFF, 0);
		send_frame(24'h000000, 24'hFFFFFF, 0);
		drain();
		write_reg(CFG_TRIM, 65536);
		write_reg(CFG_OFFSET, 0);
		send_frame(24'h7FFFFF, 24'h123456, 0);
		send_frame(24'h800000, 24'h800000, 0);
		drain();
		write_reg(CFG_TRIM, 8000);
		write_reg(CFG_OFFSET, 127);
		write_reg(CFG_WET, 65535);
		for (int i = 0; i < 8; i++)
			send_frame(rand_sample(), rand_sample(), 0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_TRIM, ph < 4 ? TRIMS[ph] : $urandom_range(16384, 65536));
			write_reg(CFG_OFFSET, ph < 4 ? OFSS[ph] : $urandom_range(1, 127));
			write_reg(CFG_WET, ph < 4 ? WETS[ph] : $urandom_range(0, 32768));
			if (ph == 2)
				hold_out = 1'b1;
			for (int i = 0; i < 125; i++)
				send_frame(rand_sample(), rand_sample(), $urandom_range(0, 4) != 0);
			drain();
		end

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
